// ----- sv/tans_factorized_symbol_decoder_macros.svh -----
// ============================================================================
// tANS symbol decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ============================================================================
`ifndef TANS_FACTORIZED_SYMBOL_DECODER_MACROS_SVH
`define TANS_FACTORIZED_SYMBOL_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfsd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfsd assertion failed");

`endif

// ----- sv/tfsd_pkg.sv -----
// ============================================================================
// tANS symbol decoder package
// Widths, command codes and the structs passed between decoder modules.
// ============================================================================
package tfsd_pkg;

    localparam int STORE_DEPTH     = 32;
    localparam int IDX_W           = 5;
    localparam int STATE_W         = 8;
    localparam int SYM_W           = 6;
    localparam int BITS_W          = 5;
    localparam int WINDOW_W        = 16;
    localparam int COUNT_W         = 9;
    localparam int SHIFT_W         = 4;
    localparam int LITERAL_BITS    = 6;
    localparam int NUM_SYMBOLS_DEF = 32;

    localparam logic [STATE_W-1:0] ESCAPE_STATE = 8'hFF;
    localparam logic [BITS_W-1:0]  BITS_INIT    = 5'd16;

    typedef enum logic [1:0] {
        CMD_LOAD_CDF = 2'd0,
        CMD_INIT     = 2'd1,
        CMD_DECODE   = 2'd2,
        CMD_LITERAL  = 2'd3
    } cmd_t;

    // Interval search result for the selected state.
    typedef struct packed {
        logic               found;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] lo;
        logic [STATE_W-1:0] hi;
    } lookup_t;

    // Renormalization result.
    typedef struct packed {
        logic [STATE_W-1:0] next_state;
        logic [BITS_W-1:0]  n_bits;
    } renorm_t;

endpackage

// ----- sv/tans_factorized_symbol_decoder.sv -----
// ============================================================================
// tANS factorized symbol decoder
// Two interleaved 8-bit table-ANS states with a loadable cdf store.
// ============================================================================
// Every request produces exactly one result. The decoder takes one request
// per clock while the consumer keeps taking results. The request is
// registered, then the cdf interval search, count forming, renormalization
// shift and window refill run combinationally into the result register. The
// throughput is set by that combinational loop through the selected ANS
// state, so back-to-back decodes on the same state need no gaps. A full result
// register does not block intake as long as the consumer keeps taking results.
module tans_factorized_symbol_decoder #(
    parameter int NUM_SYMBOLS = tfsd_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [tfsd_pkg::IDX_W-1:0]    cdf_index,
    input  logic [tfsd_pkg::STATE_W-1:0]  cdf_value,
    input  logic                          state_select,
    input  logic [tfsd_pkg::WINDOW_W-1:0] bit_window,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tfsd_pkg::SYM_W-1:0]    symbol,
    output logic                          is_escape,
    output logic [tfsd_pkg::BITS_W-1:0]   bits_used
);

`include "tans_factorized_symbol_decoder_macros.svh"

    localparam int IDX_W        = tfsd_pkg::IDX_W;
    localparam int STATE_W      = tfsd_pkg::STATE_W;
    localparam int SYM_W        = tfsd_pkg::SYM_W;
    localparam int BITS_W       = tfsd_pkg::BITS_W;
    localparam int WINDOW_W     = tfsd_pkg::WINDOW_W;
    localparam int LITERAL_BITS = tfsd_pkg::LITERAL_BITS;

    // Request register
    logic                  in_valid_reg;
    logic                  in_valid_next;
    tfsd_pkg::cmd_t        cmd_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [STATE_W-1:0]    val_reg;
    logic                  sel_reg;
    logic [WINDOW_W-1:0]   win_reg;

    // ANS states
    logic [STATE_W-1:0]    state_a_reg;
    logic [STATE_W-1:0]    state_a_next;
    logic [STATE_W-1:0]    state_b_reg;
    logic [STATE_W-1:0]    state_b_next;

    // Result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [SYM_W-1:0]      symbol_reg;
    logic [SYM_W-1:0]      symbol_next;
    logic                  is_escape_reg;
    logic                  is_escape_next;
    logic [BITS_W-1:0]     bits_used_reg;
    logic [BITS_W-1:0]     bits_used_next;

    logic                  in_accept;
    logic                  advance;
    logic [STATE_W-1:0]    sel_state;
    logic [STATE_W-1:0]    decoded_state;
    tfsd_pkg::lookup_t     lookup;
    tfsd_pkg::renorm_t     renorm;

    // The pending request moves on whenever the result register is free or drains.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    assign in_valid_next  = in_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    assign sel_state = sel_reg ? state_b_reg : state_a_reg;

    tfsd_cdf_lookup #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_lookup (
        .clk       (clk),
        .wr_en     (advance && (cmd_reg == tfsd_pkg::CMD_LOAD_CDF)),
        .wr_index  (idx_reg),
        .wr_value  (val_reg),
        .state_val (sel_state),
        .result    (lookup)
    );

    tfsd_renorm u_renorm (
        .lookup     (lookup),
        .state_val  (sel_state),
        .window_top (win_reg[WINDOW_W-1 -: STATE_W]),
        .result     (renorm)
    );

    always_comb
    begin
        symbol_next    = '0;
        is_escape_next = 1'b0;
        bits_used_next = '0;
        state_a_next   = state_a_reg;
        state_b_next   = state_b_reg;
        decoded_state  = renorm.next_state;
        unique case (cmd_reg)
            tfsd_pkg::CMD_LOAD_CDF:
            begin
                bits_used_next = '0;
            end
            tfsd_pkg::CMD_INIT:
            begin
                state_a_next   = win_reg[WINDOW_W-1 -: STATE_W];
                state_b_next   = win_reg[STATE_W-1:0];
                bits_used_next = tfsd_pkg::BITS_INIT;
            end
            tfsd_pkg::CMD_DECODE:
            begin
                if (lookup.found)
                begin
                    symbol_next    = lookup.sym;
                    bits_used_next = renorm.n_bits;
                end
                else
                begin
                    // Escape state or an uncovered state reloads from the window.
                    symbol_next    = SYM_W'(NUM_SYMBOLS);
                    is_escape_next = 1'b1;
                    bits_used_next = BITS_W'(STATE_W);
                    decoded_state  = win_reg[WINDOW_W-1 -: STATE_W];
                end
                if (sel_reg)
                begin
                    state_b_next = decoded_state;
                end
                else
                begin
                    state_a_next = decoded_state;
                end
            end
            tfsd_pkg::CMD_LITERAL:
            begin
                symbol_next    = win_reg[WINDOW_W-1 -: SYM_W];
                bits_used_next = BITS_W'(LITERAL_BITS);
            end
            default:
            begin
                bits_used_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_a_reg   <= '0;
            state_b_reg   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_a_reg <= state_a_next;
                state_b_reg <= state_b_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= tfsd_pkg::cmd_t'(cmd);
            idx_reg <= cdf_index;
            val_reg <= cdf_value;
            sel_reg <= state_select;
            win_reg <= bit_window;
        end
        if (advance)
        begin
            symbol_reg    <= symbol_next;
            is_escape_reg <= is_escape_next;
            bits_used_reg <= bits_used_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign is_escape = is_escape_reg;
    assign bits_used = bits_used_reg;

    `TFSD_ASSERT_IMPLIES(a_escape_bits, clk, rst_n, out_valid_reg && is_escape_reg,
        bits_used_reg == BITS_W'(STATE_W))
    `TFSD_ASSERT_IMPLIES(a_bits_range, clk, rst_n, out_valid_reg,
        bits_used_reg <= tfsd_pkg::BITS_INIT)
    `TFSD_ASSERT_NEXT(a_load_keeps_state, clk, rst_n,
        advance && (cmd_reg == tfsd_pkg::CMD_LOAD_CDF),
        $stable(state_a_reg) && $stable(state_b_reg))
    `TFSD_ASSERT_NEXT(a_pending_held, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(win_reg))

endmodule

// ----- sv/tfsd_cdf_lookup.sv -----
// ============================================================================
// tANS cdf store and interval search
// Holds the cumulative frequency ends and finds the symbol covering a state.
// ============================================================================
module tfsd_cdf_lookup #(
    parameter int NUM_SYMBOLS = tfsd_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [tfsd_pkg::IDX_W-1:0]   wr_index,
    input  logic [tfsd_pkg::STATE_W-1:0] wr_value,
    input  logic [tfsd_pkg::STATE_W-1:0] state_val,
    output tfsd_pkg::lookup_t            result
);

    localparam int STORE_DEPTH = tfsd_pkg::STORE_DEPTH;
    localparam int STATE_W     = tfsd_pkg::STATE_W;
    localparam int SYM_W       = tfsd_pkg::SYM_W;
    // Symbols beyond the store get no lane and never match.
    localparam int LANES = (NUM_SYMBOLS < STORE_DEPTH) ? NUM_SYMBOLS : STORE_DEPTH;

    logic [STATE_W-1:0] cdf_mem [STORE_DEPTH];
    logic [STATE_W-1:0] lane_lo [LANES];
    logic [STATE_W-1:0] lane_hi [LANES];
    logic [LANES-1:0]   hit;
    tfsd_pkg::lookup_t  pick;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cdf_mem[wr_index] <= wr_value;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        if (g == 0)
        begin : g_first
            assign lane_lo[g] = '0;
        end
        else
        begin : g_rest
            assign lane_lo[g] = cdf_mem[g-1];
        end
        assign lane_hi[g] = cdf_mem[g];
        assign hit[g]     = (lane_lo[g] <= state_val) && (state_val < lane_hi[g]);
    end

    // Highest matching symbol wins when intervals overlap.
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (hit[i])
            begin
                pick.sym = SYM_W'(i);
                pick.lo  = lane_lo[i];
                pick.hi  = lane_hi[i];
            end
        end
        pick.found = (|hit) && (state_val != tfsd_pkg::ESCAPE_STATE);
    end

    assign result = pick;

endmodule

// ----- sv/tfsd_renorm.sv -----
// ============================================================================
// tANS state renormalization
// Forms the interval count, finds the shift and refills the low state bits.
// ============================================================================
module tfsd_renorm (
    input  tfsd_pkg::lookup_t            lookup,
    input  logic [tfsd_pkg::STATE_W-1:0] state_val,
    input  logic [tfsd_pkg::STATE_W-1:0] window_top,
    output tfsd_pkg::renorm_t            result
);

    localparam int STATE_W = tfsd_pkg::STATE_W;
    localparam int COUNT_W = tfsd_pkg::COUNT_W;
    localparam int SHIFT_W = tfsd_pkg::SHIFT_W;
    localparam int BITS_W  = tfsd_pkg::BITS_W;

    logic [COUNT_W-1:0] count;
    logic [SHIFT_W-1:0] shift;
    logic [STATE_W-1:0] refill;

    assign count = {1'b0, lookup.hi - lookup.lo} + {1'b0, state_val - lookup.lo};

    // The shift is the number of leading zeros of the count within nine bits, eight for a zero count.
    always_comb
    begin
        shift = SHIFT_W'(STATE_W);
        if (count[COUNT_W-1])
        begin
            shift = '0;
        end
        else
        begin
            for (int b = 0; b < STATE_W; b++)
            begin
                if (count[b])
                begin
                    shift = SHIFT_W'(STATE_W - b);
                end
            end
        end
    end

    assign refill = window_top >> (SHIFT_W'(STATE_W) - shift);

    assign result.next_state = (count[STATE_W-1:0] << shift) | refill;
    assign result.n_bits     = BITS_W'(shift);

endmodule
